>>> sv/lpgc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpgc_pkg
// Shared types and constants of the loopback packet generator and checker.
// ----------------------------------------------------------------------------
package lpgc_pkg;

  localparam int unsigned MAX_DATA      = 64;
  localparam int unsigned TIMEOUT_LIMIT = 5;

  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_ADD = 32'd12345;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_UNIT        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LINE        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_MASK = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ERROR_LIMIT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SEED        = 3'd4;

  localparam logic [5:0]  RESET_LENGTH_MASK = 6'd63;
  localparam logic [15:0] RESET_ERROR_LIMIT = 16'd10;
  localparam logic [31:0] RESET_SEED        = 32'd0;

  // request opcodes
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_SEND    = 2'd1;
  localparam logic [1:0] OP_RECEIVE = 2'd2;
  localparam logic [1:0] OP_TIMEOUT = 2'd3;

  // result status codes
  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_PASS    = 3'd1;
  localparam logic [2:0] ST_FAIL    = 3'd2;
  localparam logic [2:0] ST_NO_DATA = 3'd3;
  localparam logic [2:0] ST_DESEL   = 3'd4;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic        tx_last;
    logic        checksum_bad;
    logic        data_bad;
    logic [6:0]  packet_length;
    logic [6:0]  received_count;
    logic [15:0] good_total;
    logic [15:0] error_total;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic mul;
    logic add_first;
    logic add_second;
    logic sum;
    logic load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start_go;
    logic sum_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

>>> sv/lpgc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpgc_ctrl
// Sequencer: takes one request, runs it through the datapath, then hands the
// result to the output register.
// ----------------------------------------------------------------------------
module lpgc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire lpgc_pkg::sts_t sts,
  output lpgc_pkg::cmd_t      cmd
);
  import lpgc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL1,
    S_ADD1,
    S_MUL2,
    S_ADD2,
    S_SUM,
    S_OUT
  } state_t;

  state_t state;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: cmd.capture    = in_valid;
      S_EXEC: cmd.exec       = 1'b1;
      S_MUL1: cmd.mul        = 1'b1;
      S_ADD1: cmd.add_first  = 1'b1;
      S_MUL2: cmd.mul        = 1'b1;
      S_ADD2: cmd.add_second = 1'b1;
      S_SUM:  cmd.sum        = 1'b1;
      S_OUT:  cmd.load       = sts.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (in_valid) state <= S_EXEC;
        S_EXEC: state <= sts.start_go ? S_MUL1 : S_OUT;
        S_MUL1: state <= S_ADD1;
        S_ADD1: state <= S_MUL2;
        S_MUL2: state <= S_ADD2;
        S_ADD2: state <= S_SUM;
        S_SUM:  if (sts.sum_last) state <= S_OUT;
        S_OUT:  if (sts.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.exec, cmd.mul, cmd.add_first, cmd.add_second,
              cmd.sum, cmd.load}))
    else $error("more than one datapath command");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> sts.out_free)
    else $error("result loaded into a full output register");

  a_start_seq: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && sts.start_go) |=> cmd.mul ##1 cmd.add_first)
    else $error("start request did not run the generator");

endmodule
`default_nettype wire

>>> sv/lpgc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpgc_datapath
// Packet state, generator, checksum accumulator, configuration registers and
// the output register.
// ----------------------------------------------------------------------------
module lpgc_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire lpgc_pkg::cmd_t                      cmd,
  output lpgc_pkg::sts_t                           sts,
  input  wire lpgc_pkg::in_item_t                  in_item,
  input  wire logic                                cfg_write,
  input  wire logic [lpgc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [lpgc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output lpgc_pkg::out_item_t                      out_item
);
  import lpgc_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ACTIVE,
    PH_DESEL
  } phase_t;

  function automatic logic [15:0] sext8(input logic [7:0] b);
    return {{8{b[7]}}, b};
  endfunction

  // configuration
  logic [7:0]  unit_number;
  logic [7:0]  line_number;
  logic [5:0]  length_mask;
  logic [15:0] data_error_limit;

  // model state
  logic [31:0] generator_state;
  phase_t      phase;
  logic [6:0]  total_length;
  logic [7:0]  pattern_start;
  logic [6:0]  send_index;
  logic [15:0] packet_checksum;
  logic [6:0]  recv_index;
  logic [15:0] recv_sum;
  logic [7:0]  recv_hold_older;
  logic [7:0]  recv_hold_newer;
  logic        mismatch_seen;
  logic [2:0]  timeout_count;
  logic [15:0] fail_count;
  logic [15:0] pass_total;
  logic [15:0] fail_total;

  // working registers
  in_item_t    item;
  logic [31:0] prod;
  logic [6:0]  data_len;
  logic [6:0]  sum_j;
  logic [15:0] acc;
  logic [2:0]  res_status;
  logic [7:0]  res_tx_byte;
  logic        res_tx_valid;
  logic        res_tx_last;
  logic        res_cs_bad;
  logic        res_dt_bad;

  function automatic logic [7:0] expected_byte(
    input logic [6:0] k, input logic [7:0] unit_b, input logic [7:0] line_b,
    input logic [7:0] pstart);
    logic [7:0] r;
    if (k == 7'd0)      r = unit_b;
    else if (k == 7'd1) r = line_b;
    else                r = pstart + {1'b0, k} - 8'd2;
    return r;
  endfunction

  // generator and length
  logic [31:0] lcg_next;
  logic [6:0]  n_raw;
  logic [6:0]  n_sat;
  logic [15:0] acc_step;

  assign lcg_next = prod + LCG_ADD;
  assign n_raw    = {1'b0, lcg_next[21:16] & length_mask} + 7'd1;
  assign n_sat    = (n_raw > 7'(MAX_DATA)) ? 7'(MAX_DATA) : n_raw;
  assign acc_step = acc + sext8(pattern_start + {1'b0, sum_j});

  // combinational request evaluation
  phase_t      ex_phase;
  logic [6:0]  ex_send;
  logic [6:0]  ex_ridx;
  logic [15:0] ex_rsum;
  logic [7:0]  ex_old;
  logic [7:0]  ex_new;
  logic        ex_mism;
  logic [2:0]  ex_tc;
  logic [15:0] ex_fail;
  logic [15:0] ex_pass_t;
  logic [15:0] ex_fail_t;
  logic [2:0]  ex_stat;
  logic [7:0]  ex_txb;
  logic        ex_txv;
  logic        ex_txl;
  logic        ex_cs;
  logic        ex_dt;
  logic        start_go;
  logic        do_vd;
  logic        receiving;
  logic        shorter;
  logic [15:0] vd_word;
  logic [15:0] rx_add;

  assign receiving = (phase == PH_ACTIVE) && (send_index != 7'd0);

  always_comb begin
    ex_phase  = phase;
    ex_send   = send_index;
    ex_ridx   = recv_index;
    ex_rsum   = recv_sum;
    ex_old    = recv_hold_older;
    ex_new    = recv_hold_newer;
    ex_mism   = mismatch_seen;
    ex_tc     = timeout_count;
    ex_fail   = fail_count;
    ex_pass_t = pass_total;
    ex_fail_t = fail_total;
    ex_stat   = ST_NONE;
    ex_txb    = 8'd0;
    ex_txv    = 1'b0;
    ex_txl    = 1'b0;
    ex_cs     = 1'b0;
    ex_dt     = 1'b0;
    start_go  = 1'b0;
    do_vd     = 1'b0;
    shorter   = 1'b0;
    vd_word   = 16'd0;
    rx_add    = 16'd0;

    if (phase == PH_DESEL) begin
      ex_stat = ST_DESEL;
    end else begin
      case (item.op)
        OP_START: begin
          if (phase == PH_IDLE) begin
            if (fail_count >= data_error_limit) begin
              ex_phase = PH_DESEL;
              ex_stat  = ST_DESEL;
            end else begin
              start_go = 1'b1;
            end
          end
        end
        OP_SEND: begin
          if (phase == PH_ACTIVE && send_index < total_length) begin
            if (send_index + 7'd2 < total_length) begin
              ex_txb = expected_byte(send_index, unit_number, line_number,
                                     pattern_start);
            end else if (send_index + 7'd2 == total_length) begin
              ex_txb = packet_checksum[7:0];
            end else begin
              ex_txb = packet_checksum[15:8];
              ex_txl = 1'b1;
            end
            ex_txv  = 1'b1;
            ex_send = send_index + 7'd1;
          end
        end
        OP_RECEIVE: begin
          if (receiving && recv_index < total_length) begin
            if (recv_index + 7'd2 < total_length &&
                item.rx_byte != expected_byte(recv_index, unit_number,
                                              line_number, pattern_start))
              ex_mism = 1'b1;
            // the byte now leaving the older hold joins the running sum
            if (recv_index >= 7'd2) rx_add = sext8(recv_hold_older);
            ex_rsum = recv_sum + rx_add;
            ex_old  = recv_hold_newer;
            ex_new  = item.rx_byte;
            ex_ridx = recv_index + 7'd1;
            do_vd   = (ex_ridx == total_length);
          end
        end
        OP_TIMEOUT: begin
          if (receiving) begin
            if (timeout_count != 3'd7) ex_tc = timeout_count + 3'd1;
            if (ex_tc >= 3'(TIMEOUT_LIMIT)) begin
              ex_phase = PH_DESEL;
              ex_stat  = ST_DESEL;
            end else if (recv_index != 7'd0) begin
              do_vd = 1'b1;
            end else begin
              ex_phase = PH_IDLE;
              ex_stat  = ST_NO_DATA;
            end
          end
        end
        default: ex_stat = ST_NONE;
      endcase
    end

    if (do_vd) begin
      shorter = (ex_ridx != total_length);
      if (ex_ridx >= 7'd2)      vd_word = {ex_new, ex_old};
      else if (ex_ridx == 7'd1) vd_word = {8'd0, ex_new};
      ex_cs    = (ex_rsum == 16'd0 && shorter) || (ex_rsum + vd_word != 16'd0);
      ex_dt    = shorter || ex_mism;
      ex_phase = PH_IDLE;
      if (!ex_cs && !ex_dt) begin
        ex_pass_t = pass_total + 16'd1;
        ex_stat   = ST_PASS;
      end else begin
        ex_fail_t = fail_total + 16'd1;
        if (fail_count != 16'hFFFF) ex_fail = fail_count + 16'd1;
        ex_stat = ST_FAIL;
      end
    end
  end

  assign sts.start_go = start_go;
  assign sts.sum_last = (sum_j == data_len - 7'd1);
  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_number      <= 8'd0;
      line_number      <= 8'd0;
      length_mask      <= RESET_LENGTH_MASK;
      data_error_limit <= RESET_ERROR_LIMIT;
      generator_state  <= RESET_SEED;
      phase            <= PH_IDLE;
      total_length     <= 7'd0;
      pattern_start    <= 8'd0;
      send_index       <= 7'd0;
      packet_checksum  <= 16'd0;
      recv_index       <= 7'd0;
      recv_sum         <= 16'd0;
      recv_hold_older  <= 8'd0;
      recv_hold_newer  <= 8'd0;
      mismatch_seen    <= 1'b0;
      timeout_count    <= 3'd0;
      fail_count       <= 16'd0;
      pass_total       <= 16'd0;
      fail_total       <= 16'd0;
      out_valid        <= 1'b0;
    end else begin
      if (cmd.capture) item <= in_item;

      if (cmd.exec) begin
        phase           <= ex_phase;
        send_index      <= ex_send;
        recv_index      <= ex_ridx;
        recv_sum        <= ex_rsum;
        recv_hold_older <= ex_old;
        recv_hold_newer <= ex_new;
        mismatch_seen   <= ex_mism;
        timeout_count   <= ex_tc;
        fail_count      <= ex_fail;
        pass_total      <= ex_pass_t;
        fail_total      <= ex_fail_t;
        res_status      <= ex_stat;
        res_tx_byte     <= ex_txb;
        res_tx_valid    <= ex_txv;
        res_tx_last     <= ex_txl;
        res_cs_bad      <= ex_cs;
        res_dt_bad      <= ex_dt;
      end

      if (cmd.mul) prod <= generator_state * LCG_MUL;

      if (cmd.add_first) begin
        generator_state <= lcg_next;
        data_len        <= n_sat;
      end

      if (cmd.add_second) begin
        generator_state <= lcg_next;
        pattern_start   <= lcg_next[23:16];
        acc             <= sext8(unit_number) + sext8(line_number);
        sum_j           <= 7'd0;
      end

      if (cmd.sum) begin
        acc   <= acc_step;
        sum_j <= sum_j + 7'd1;
        if (sts.sum_last) begin
          packet_checksum <= 16'd0 - acc_step;
          total_length    <= data_len + 7'd4;
          send_index      <= 7'd0;
          recv_index      <= 7'd0;
          recv_sum        <= 16'd0;
          recv_hold_older <= 8'd0;
          recv_hold_newer <= 8'd0;
          mismatch_seen   <= 1'b0;
          phase           <= PH_ACTIVE;
        end
      end

      if (cfg_write) begin
        case (cfg_index)
          REG_UNIT:        unit_number      <= cfg_data[7:0];
          REG_LINE:        line_number      <= cfg_data[7:0];
          REG_LENGTH_MASK: length_mask      <= cfg_data[5:0];
          REG_ERROR_LIMIT: data_error_limit <= cfg_data[15:0];
          REG_SEED:        generator_state  <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.load) begin
        out_valid <= 1'b1;
        out_item  <= '{status:         res_status,
                       tx_byte:        res_tx_byte,
                       tx_valid:       res_tx_valid,
                       tx_last:        res_tx_last,
                       checksum_bad:   res_cs_bad,
                       data_bad:       res_dt_bad,
                       packet_length:  total_length,
                       received_count: recv_index,
                       good_total:     pass_total,
                       error_total:    fail_total};
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_desel_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DESEL |=> phase == PH_DESEL)
    else $error("deselected line came back");

  a_desel_status: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && res_status == ST_DESEL) |-> phase == PH_DESEL)
    else $error("deselect reported on a selected line");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.received_count <= out_item.packet_length)
    else $error("more bytes received than the packet holds");

endmodule
`default_nettype wire

>>> sv/loopback_packet_gen_check_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// loopback_packet_gen_check_unit
// Loopback packet generator and checker for one serial line.
// ----------------------------------------------------------------------------
// Sequence: send, receive and timeout requests, and a start that opens no
//   packet, are evaluated and then loaded into the output register once it is free;
//   a start that opens a packet also runs the generator (multiply, add, multiply,
//   add) and the one-byte-per-cycle checksum sum over the drawn data length (1..64).
// Requests: one at a time; a new request is taken only after the last result is loaded.
// Reset: synchronous; state and configuration registers return to defaults, generator loaded from seed.
module loopback_packet_gen_check_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire lpgc_pkg::in_item_t                in_item,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output lpgc_pkg::out_item_t                    out_item,
  input  wire logic                              cfg_write,
  input  wire logic [lpgc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [lpgc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lpgc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lpgc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lpgc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
